/* sv/rsaf_pkg.sv */
// ----------------------------------------------------------------------------
// rsaf_pkg: shared types and constants of the register slot allocator
// Transfer payloads, opcodes and field widths used by the allocator top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rsaf_pkg;

   localparam int NUM_SLOTS_DEF = 20;
   localparam int SLOT_W        = 5;
   localparam int VAR_W         = 16;
   localparam int AGE_W         = 16;
   localparam int OP_W          = 2;

   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

   localparam logic [OP_W-1:0] OP_VAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_CONST = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [VAR_W-1:0] var_id;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              hit;
      logic              evicted;
      logic [VAR_W-1:0]  evicted_var_id;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

/* sv/register_slot_allocator_fifo.sv */
// ----------------------------------------------------------------------------
// register_slot_allocator_fifo: fully associative slot allocator, age eviction
// Maps variable identifiers onto register slots, evicting the oldest occupant
// when no slot is free. One slot is examined per cycle by a shared comparator.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    rsaf_pkg::req_type (opcode, var_id)
//   rsp_     out        rsp_valid/stall    rsaf_pkg::rsp_type (slot, hit, ...)
//
// A request or constant is handled by a scan that visits one slot per cycle
// through a single match / free / age compare unit, then one commit.
// A hit ends the scan at the matching slot. Flush and the unused opcode skip
// the scan and go straight to the commit. Reset empties every slot at once. The result register decouples
// the sides: a new request is taken while a result waits, and the commit of
// the following item holds until that result has transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module register_slot_allocator_fifo #(
   parameter int NUM_SLOTS = rsaf_pkg::NUM_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rsaf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsaf_pkg::rsp_type      rsp_data
);
   import rsaf_pkg::*;

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

   // slot storage
   logic [NUM_SLOTS-1:0] slot_valid_ff;
   logic [NUM_SLOTS-1:0] slot_const_ff;
   logic [VAR_W-1:0]     slot_var_ff [NUM_SLOTS];
   logic [AGE_W-1:0]     slot_age_ff [NUM_SLOTS];

   // sequencer and scan results
   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [AGE_W-1:0] best_age_ff;
   logic [IDX_W-1:0] old_idx_ff;
   logic             old_const_ff;
   logic [VAR_W-1:0] old_var_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // shared compare unit on the slot under the scan pointer
   logic             cur_valid;
   logic             cur_match;
   logic [AGE_W-1:0] cur_aged;
   logic             cur_older;
   logic             out_free;
   logic             commit;
   logic             alloc;
   logic [IDX_W-1:0] pick;
   rsp_type          rsp_in;

   assign cur_valid = slot_valid_ff[idx_ff];
   assign cur_match = cur_valid && !slot_const_ff[idx_ff]
                      && (slot_var_ff[idx_ff] == req_ff.var_id)
                      && (req_ff.opcode == OP_VAR);
   assign cur_aged  = (slot_age_ff[idx_ff] == AGE_MAX) ? AGE_MAX
                      : slot_age_ff[idx_ff] + AGE_W'(1);
   assign cur_older = (idx_ff == '0) || (cur_aged > best_age_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_FINISH) && out_free;
   assign alloc    = !hit_ff && (req_ff.opcode == OP_VAR || req_ff.opcode == OP_CONST);
   assign pick     = free_found_ff ? free_idx_ff : old_idx_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_in = '0;
      if (hit_ff) begin
         rsp_in.slot_index = SLOT_W'(hit_idx_ff);
         rsp_in.hit        = 1'b1;
      end else if (alloc) begin
         rsp_in.slot_index = SLOT_W'(pick);
         if (!free_found_ff) begin
            rsp_in.evicted        = 1'b1;
            rsp_in.evicted_var_id = old_const_ff ? '0 : old_var_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_VAR || req_data.opcode == OP_CONST) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (cur_match || idx_ff == IDX_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff        <= req_data;
         idx_ff        <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (cur_match) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         // lowest index wins ties: replace only on strictly older
         if (cur_older) begin
            best_age_ff  <= cur_aged;
            old_idx_ff   <= idx_ff;
            old_const_ff <= slot_const_ff[idx_ff];
            old_var_ff   <= slot_var_ff[idx_ff];
         end
         if (idx_ff != IDX_LAST) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // slot state: flush empties every slot; a miss ages every occupant, then installs the new occupant
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (commit) begin
         if (req_ff.opcode == OP_FLUSH) begin
            slot_valid_ff <= '0;
         end else if (alloc) begin
            slot_valid_ff[pick] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit && alloc) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (IDX_W'(i) == pick) begin
               slot_age_ff[i] <= '0;
            end else if (slot_valid_ff[i] && slot_age_ff[i] != AGE_MAX) begin
               slot_age_ff[i] <= slot_age_ff[i] + AGE_W'(1);
            end
         end
         slot_const_ff[pick] <= (req_ff.opcode == OP_CONST);
         slot_var_ff[pick]   <= (req_ff.opcode == OP_CONST) ? '0 : req_ff.var_id;
      end
   end

   // ------------------------------------------------------------------------
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.hit && rsp_data_ff.evicted))
      else $error("hit result reports an eviction");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.slot_index < SLOT_W'(NUM_SLOTS)))
      else $error("slot index out of range");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (commit && req_ff.opcode == OP_FLUSH) |=> (slot_valid_ff == '0))
      else $error("flush left occupied slots");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (commit && alloc && !free_found_ff) |-> (&slot_valid_ff))
      else $error("eviction while a free slot exists");

endmodule

`default_nettype wire

/* dv/slot_grant_checker.sv */
// ----------------------------------------------------------------------------
// slot_grant_checker: result predictor and scoreboard for the slot allocator
// Watches both transfer channels, keeps its own copy of the slot table, and
// compares every result against the grant predicted for the oldest request.
// ----------------------------------------------------------------------------
module slot_grant_checker #(
   parameter int NUM_SLOTS = rsaf_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rsaf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsaf_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                grants_pending,
   output int                grants_checked,
   output int                hit_count,
   output int                evict_count
);
   import rsaf_pkg::*;

   logic             slot_used  [NUM_SLOTS];
   logic             slot_const [NUM_SLOTS];
   logic [VAR_W-1:0] slot_id    [NUM_SLOTS];
   logic [AGE_W-1:0] slot_age   [NUM_SLOTS];

   rsp_type grants_due [$];
   int      mismatches;
   int      checked;
   int      hits;
   int      evictions;

   function automatic void empty_slots();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_used[i]  = 1'b0;
         slot_const[i] = 1'b0;
         slot_id[i]    = '0;
         slot_age[i]   = '0;
      end
   endfunction

   // Advance the slot table by one request and return the grant it produces.
   function automatic rsp_type predict_grant(req_type item);
      rsp_type          grant;
      int               pick;
      bit               matched;
      bit               found;
      logic [AGE_W-1:0] oldest;
      grant   = '0;
      pick    = 0;
      matched = 1'b0;
      found   = 1'b0;
      if (item.opcode == OP_FLUSH) begin
         empty_slots();
      end else if (item.opcode == OP_VAR || item.opcode == OP_CONST) begin
         if (item.opcode == OP_VAR) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!matched && slot_used[i] && !slot_const[i] && slot_id[i] == item.var_id) begin
                  matched = 1'b1;
                  pick    = i;
               end
            end
         end
         if (matched) begin
            grant.slot_index = SLOT_W'(pick);
            grant.hit        = 1'b1;
         end else begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_used[i] && slot_age[i] != AGE_MAX)
                  slot_age[i] = slot_age[i] + 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!found && !slot_used[i]) begin
                  found = 1'b1;
                  pick  = i;
               end
            end
            if (!found) begin
               // strict compare keeps the lowest index among equal ages
               oldest = slot_age[0];
               pick   = 0;
               for (int i = 1; i < NUM_SLOTS; i++) begin
                  if (slot_age[i] > oldest) begin
                     oldest = slot_age[i];
                     pick   = i;
                  end
               end
               grant.evicted        = 1'b1;
               grant.evicted_var_id = slot_const[pick] ? '0 : slot_id[pick];
            end
            slot_used[pick]  = 1'b1;
            slot_const[pick] = (item.opcode == OP_CONST);
            slot_id[pick]    = (item.opcode == OP_CONST) ? '0 : item.var_id;
            slot_age[pick]   = '0;
            grant.slot_index = SLOT_W'(pick);
         end
      end
      return grant;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         empty_slots();
         grants_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected result: slot %0d hit %b evicted %b evicted_var %h",
                           $time, rsp_data.slot_index, rsp_data.hit, rsp_data.evicted,
                           rsp_data.evicted_var_id);
            end else begin
               want = grants_due.pop_front();
               checked++;
               if (rsp_data.slot_index !== want.slot_index || rsp_data.hit !== want.hit ||
                   rsp_data.evicted !== want.evicted ||
                   rsp_data.evicted_var_id !== want.evicted_var_id) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"[%0t] mismatch: expected slot %0d hit %b evicted %b ",
                               "evicted_var %h, got slot %0d hit %b evicted %b evicted_var %h"},
                              $time, want.slot_index, want.hit, want.evicted,
                              want.evicted_var_id, rsp_data.slot_index, rsp_data.hit,
                              rsp_data.evicted, rsp_data.evicted_var_id);
               end
               if (want.hit)
                  hits++;
               if (want.evicted)
                  evictions++;
            end
         end
         if (req_valid && !req_stall)
            grants_due.push_back(predict_grant(req_data));
      end
      // publish after the edge so the stimulus side never races the update
      mismatch_count <= mismatches;
      grants_pending <= grants_due.size();
      grants_checked <= checked;
      hit_count      <= hits;
      evict_count    <= evictions;
   end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the register slot allocator
// Drives directed and random allocation traffic through four pacing phases
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
   import rsaf_pkg::*;

   localparam int SLOTS   = NUM_SLOTS_DEF;
   localparam int LATENCY = SLOTS + 2;
   localparam int PHASE_ITEMS = 200;
   localparam int POOL_SIZE   = 24;

   // opcode the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int checked;
   int hits;
   int evictions;
   int sent;
   int idle_pct;
   int stall_pct;

   logic [VAR_W-1:0] id_pool [POOL_SIZE];

   register_slot_allocator_fifo #(
      .NUM_SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   slot_grant_checker #(
      .NUM_SLOTS(SLOTS)
   ) grant_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .mismatch_count(mismatch_count),
      .grants_pending(outstanding),
      .grants_checked(checked),
      .hit_count(hits),
      .evict_count(evictions)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Hold valid through stalls; it stays high when the next item follows at once.
   task automatic send_item(input logic [OP_W-1:0] opcode, input logic [VAR_W-1:0] id);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data.opcode <= opcode;
      req_data.var_id <= id;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent++;
   endtask

   task automatic send_random();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         send_item(OP_FLUSH, VAR_W'($urandom));
      else if (roll < 4)
         send_item(OP_UNUSED, VAR_W'($urandom));
      else if (roll < 18)
         send_item(OP_CONST, VAR_W'($urandom));
      else if (roll < 82)
         send_item(OP_VAR, id_pool[$urandom_range(0, POOL_SIZE - 1)]);
      else
         send_item(OP_VAR, VAR_W'($urandom));
   endtask

   initial begin
      idle_pct  = 0;
      stall_pct = 0;
      sent      = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // constant first, so a later request for id zero must miss
      send_item(OP_CONST, 16'hffff);
      send_item(OP_VAR, 16'h0000);
      send_item(OP_VAR, 16'h0000);
      send_item(OP_VAR, 16'hffff);
      send_item(OP_UNUSED, 16'h1234);
      for (int i = 0; i < SLOTS - 3; i++)
         send_item(OP_VAR, 16'h5550 + VAR_W'(i));
      // table is full: displace the constant, then variable zero
      send_item(OP_VAR, 16'haaaa);
      send_item(OP_VAR, 16'h1234);
      send_item(OP_FLUSH, 16'h0000);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 61;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 61;
            end
            default: begin
               idle_pct  = 36;
               stall_pct = 36;
            end
         endcase
         for (int j = 0; j < POOL_SIZE; j++)
            id_pool[j] = VAR_W'($urandom);
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_random();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      $display("sent %0d requests over four pacing phases, directed fill and eviction first",
               sent);
      $display("compared %0d results: %0d hits, %0d evictions", checked, hits, evictions);
      if (mismatch_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
sv/rsaf_pkg.sv
sv/register_slot_allocator_fifo.sv
dv/slot_grant_checker.sv
dv/testbench.sv
